// ===== design/gpd_pkg.sv =====
package gpd_pkg;

    // Field and arithmetic widths
    localparam int COORD_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int TAB_W      = 17;   // table entries, Q1.16, up to 1.0 inclusive
    localparam int U_FRAC_W   = 28;   // exponent argument u below 16.0 in Q.24
    localparam int FAC_SUM_W  = 47;
    localparam int PROD_W     = 50;
    localparam int NUM_STAGES = 12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Z  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLOFF  = 3'd6;

    localparam logic [COORD_W-1:0] FALLOFF_RESET = 32'h0100_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_point;

    // Q.31 Taylor series of exp(-f), through the fourteenth power
    function automatic logic [63:0] exp_series(input logic [63:0] f);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = 64'h8000_0000;
        term = 64'h8000_0000;
        term = ((term * f) >> 31) / 64'd1;  sum = sum - term;
        term = ((term * f) >> 31) / 64'd2;  sum = sum + term;
        term = ((term * f) >> 31) / 64'd3;  sum = sum - term;
        term = ((term * f) >> 31) / 64'd4;  sum = sum + term;
        term = ((term * f) >> 31) / 64'd5;  sum = sum - term;
        term = ((term * f) >> 31) / 64'd6;  sum = sum + term;
        term = ((term * f) >> 31) / 64'd7;  sum = sum - term;
        term = ((term * f) >> 31) / 64'd8;  sum = sum + term;
        term = ((term * f) >> 31) / 64'd9;  sum = sum - term;
        term = ((term * f) >> 31) / 64'd10; sum = sum + term;
        term = ((term * f) >> 31) / 64'd11; sum = sum - term;
        term = ((term * f) >> 31) / 64'd12; sum = sum + term;
        term = ((term * f) >> 31) / 64'd13; sum = sum - term;
        term = ((term * f) >> 31) / 64'd14; sum = sum + term;
        return sum;
    endfunction

    // Table entry exp(-x) for x in Q.31, result Q1.16
    function automatic logic [TAB_W-1:0] exp_entry(input logic [63:0] x);
        logic [63:0] n;
        logic [63:0] e1;
        logic [63:0] e;
        logic [63:0] prod;
        n  = x >> 31;
        if (n > 64'd16) begin
            n = 64'd16;
        end
        e1 = exp_series(64'h8000_0000);
        e  = 64'h8000_0000;
        for (int i = 1; i <= 16; i++) begin
            if (64'(i) <= n) begin
                e = (e * e1 + 64'h4000_0000) >> 31;
            end
        end
        prod = (exp_series({33'd0, x[30:0]}) * e + (64'd1 << 45)) >> 46;
        return prod[TAB_W-1:0];
    endfunction

    // Magnitude of p - c; never exceeds 2^32 - 1
    function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] p,
                                                    input logic signed [COORD_W-1:0] c);
        logic signed [COORD_W:0] d;
        logic signed [COORD_W:0] m;
        d = (COORD_W+1)'(p) - (COORD_W+1)'(c);
        m = d[COORD_W] ? -d : d;
        return m[COORD_W-1:0];
    endfunction

    // Round the scaled shift half up, add to the coordinate, saturate
    function automatic logic signed [COORD_W-1:0] move_axis(
        input logic signed [COORD_W-1:0] p,
        input logic signed [PROD_W-1:0]  prod
    );
        logic signed [PROD_W-1:0]  rnd;
        logic signed [COORD_W+1:0] disp;
        logic signed [COORD_W+1:0] sum;
        rnd  = prod + PROD_W'(32768);
        disp = $signed(rnd[PROD_W-1:16]);
        sum  = (COORD_W+2)'(p) + disp;
        if (sum > (COORD_W+2)'(64'sh7FFF_FFFF)) begin
            return 32'sh7FFF_FFFF;
        end else if (sum < -(COORD_W+2)'(64'sh8000_0000)) begin
            return 32'sh8000_0000;
        end else begin
            return sum[COORD_W-1:0];
        end
    endfunction

endpackage

// ===== design/gaussian_point_deform.sv =====
// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+------------------------------
// point in  | in        | i_in_valid / o_in_stall      | i_point_x, i_point_y, i_point_z
// moved out | out       | o_out_valid / i_out_stall    | o_moved_x, o_moved_y, o_moved_z
// config    | in        | i_cfg_wr_en                  | i_cfg_index, i_cfg_data
//
// One point per cycle unless the output stalls; the data pass a chain of stages
// (difference, square, two saturating sums, falloff multiply, exponent argument,
// table index, table read, interpolation, blend, shift multiply, round and saturate).
// Reset is synchronous: it clears the stage valid bits and loads the register defaults.
// A stalled output only holds the stages behind it that are full; empty stages keep
// filling, so new points are taken until the pipeline is packed.
module gaussian_point_deform
    import gpd_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [COORD_W-1:0]          i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [COORD_W-1:0]   i_point_x,
    input  logic signed [COORD_W-1:0]   i_point_y,
    input  logic signed [COORD_W-1:0]   i_point_z,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [COORD_W-1:0]   o_moved_x,
    output logic signed [COORD_W-1:0]   o_moved_y,
    output logic signed [COORD_W-1:0]   o_moved_z
);

    localparam int K_W  = $clog2(EXP_TABLE_DEPTH);
    localparam int D_W  = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int A_W  = U_FRAC_W + D_W;
    localparam int PT_STAGES = NUM_STAGES - 1;
    localparam logic [A_W-1:0] DEPTH_V = A_W'(EXP_TABLE_DEPTH);

    // Configuration registers
    logic signed [COORD_W-1:0] r_center_x, r_center_y, r_center_z;
    logic signed [COORD_W-1:0] r_shift_x, r_shift_y, r_shift_z;
    logic [COORD_W-1:0]        r_falloff;

    // Stage control
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_en;
    t_point                r_pt [PT_STAGES];

    // Stage payloads
    logic [COORD_W-1:0]            r_mag_x, r_mag_y, r_mag_z;
    logic [2*COORD_W-1:0]          r_sq_x, r_sq_y, r_sq_z;
    logic [2*COORD_W-1:0]          r_sum_xy, r_sq_z2;
    logic [2*COORD_W-1:0]          r_d2;
    logic [2*COORD_W-1:0]          r_pr_hi, r_pr_lo;
    logic                          r_far5, r_far6, r_far7, r_far8;
    logic [U_FRAC_W-1:0]           r_u;
    logic [K_W-1:0]                r_k;
    logic [U_FRAC_W-1:0]           r_r6, r_r7;
    logic [TAB_W-1:0]              r_tk, r_tk1;
    logic [TAB_W+U_FRAC_W:0]       r_m0;
    logic [TAB_W+U_FRAC_W-1:0]     r_m1;
    logic [TAB_W-1:0]              r_fac;
    logic signed [PROD_W-1:0]      r_prod_x, r_prod_y, r_prod_z;
    logic signed [COORD_W-1:0]     r_out_x, r_out_y, r_out_z;

    // Combinational stage results
    logic [2*COORD_W:0]            w_sum_xy, w_sum_all;
    logic [2*COORD_W-1:0]          w_u;
    logic [A_W-1:0]                w_a;
    logic [FAC_SUM_W-1:0]          w_fac_sum;
    logic [TAB_W-1:0]              w_tab_lo [EXP_TABLE_DEPTH];
    logic [TAB_W-1:0]              w_tab_hi [EXP_TABLE_DEPTH];

    // Build the exp table as constant logic: entry k and entry k+1 side by side
    for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_tab
        localparam logic [63:0] X_LO = (64'(k) << 35) / EXP_TABLE_DEPTH;
        localparam logic [63:0] X_HI = (64'(k + 1) << 35) / EXP_TABLE_DEPTH;
        assign w_tab_lo[k] = exp_entry(X_LO);
        assign w_tab_hi[k] = exp_entry(X_HI);
    end

    // Write configuration registers; drop writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_shift_x  <= '0;
            r_shift_y  <= '0;
            r_shift_z  <= '0;
            r_falloff  <= FALLOFF_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_CENTER_X: r_center_x <= $signed(i_cfg_data);
                CFG_CENTER_Y: r_center_y <= $signed(i_cfg_data);
                CFG_CENTER_Z: r_center_z <= $signed(i_cfg_data);
                CFG_SHIFT_X:  r_shift_x  <= $signed(i_cfg_data);
                CFG_SHIFT_Y:  r_shift_y  <= $signed(i_cfg_data);
                CFG_SHIFT_Z:  r_shift_z  <= $signed(i_cfg_data);
                CFG_FALLOFF:  r_falloff  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage enables: a stage loads when empty or when the stage after it moves
    always_comb begin
        w_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_out_stall;
        for (int s = NUM_STAGES - 2; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    assign o_in_stall  = !w_en[0];
    assign o_out_valid = r_vld[NUM_STAGES-1];
    assign o_moved_x   = r_out_x;
    assign o_moved_y   = r_out_y;
    assign o_moved_z   = r_out_z;

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int s = 1; s < NUM_STAGES; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // Carry the input point along for the final add
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_pt[0] <= '{x: i_point_x, y: i_point_y, z: i_point_z};
        end
        for (int s = 1; s < PT_STAGES; s++) begin
            if (w_en[s]) begin
                r_pt[s] <= r_pt[s-1];
            end
        end
    end

    // Saturating sums of squares, exponent argument, table index, interpolation
    always_comb begin
        w_sum_xy  = {1'b0, r_sq_x} + {1'b0, r_sq_y};
        w_sum_all = {1'b0, r_sum_xy} + {1'b0, r_sq_z2};
        w_u       = r_pr_hi + {32'd0, r_pr_lo[2*COORD_W-1:COORD_W]};
        w_a       = A_W'(r_u) * DEPTH_V;
        w_fac_sum = FAC_SUM_W'(r_m0) + FAC_SUM_W'(r_m1) + FAC_SUM_W'(64'd1 << 27);
    end

    // Datapath stages
    always_ff @(posedge i_clk) begin
        // distance magnitudes
        if (w_en[0]) begin
            r_mag_x <= abs_diff(i_point_x, r_center_x);
            r_mag_y <= abs_diff(i_point_y, r_center_y);
            r_mag_z <= abs_diff(i_point_z, r_center_z);
        end
        // squares
        if (w_en[1]) begin
            r_sq_x <= (2*COORD_W)'(r_mag_x) * (2*COORD_W)'(r_mag_x);
            r_sq_y <= (2*COORD_W)'(r_mag_y) * (2*COORD_W)'(r_mag_y);
            r_sq_z <= (2*COORD_W)'(r_mag_z) * (2*COORD_W)'(r_mag_z);
        end
        // x plus y, saturated
        if (w_en[2]) begin
            r_sum_xy <= w_sum_xy[2*COORD_W] ? '1 : w_sum_xy[2*COORD_W-1:0];
            r_sq_z2  <= r_sq_z;
        end
        // add z, saturated
        if (w_en[3]) begin
            r_d2 <= w_sum_all[2*COORD_W] ? '1 : w_sum_all[2*COORD_W-1:0];
        end
        // d2 times falloff, high and low halves
        if (w_en[4]) begin
            r_pr_hi <= (2*COORD_W)'(r_d2[2*COORD_W-1:COORD_W]) * (2*COORD_W)'(r_falloff);
            r_pr_lo <= (2*COORD_W)'(r_d2[COORD_W-1:0]) * (2*COORD_W)'(r_falloff);
        end
        // exponent argument, far test at 16.0
        if (w_en[5]) begin
            r_far5 <= |w_u[2*COORD_W-1:U_FRAC_W];
            r_u    <= w_u[U_FRAC_W-1:0];
        end
        // table index and interpolation weight
        if (w_en[6]) begin
            r_far6 <= r_far5;
            r_k    <= w_a[U_FRAC_W +: K_W];
            r_r6   <= w_a[U_FRAC_W-1:0];
        end
        // table read
        if (w_en[7]) begin
            r_far7 <= r_far6;
            r_tk   <= w_tab_lo[r_k];
            r_tk1  <= w_tab_hi[r_k];
            r_r7   <= r_r6;
        end
        // weighted entries
        if (w_en[8]) begin
            r_far8 <= r_far7;
            r_m0   <= (TAB_W+U_FRAC_W+1)'(r_tk)
                    * (TAB_W+U_FRAC_W+1)'((U_FRAC_W+1)'(64'd1 << U_FRAC_W)
                                          - (U_FRAC_W+1)'(r_r7));
            r_m1   <= (TAB_W+U_FRAC_W)'(r_tk1) * (TAB_W+U_FRAC_W)'(r_r7);
        end
        // blend and round to the factor
        if (w_en[9]) begin
            r_fac <= r_far8 ? '0 : w_fac_sum[U_FRAC_W +: TAB_W];
        end
        // scale the shift vector
        if (w_en[10]) begin
            r_prod_x <= PROD_W'(r_shift_x) * PROD_W'($signed({1'b0, r_fac}));
            r_prod_y <= PROD_W'(r_shift_y) * PROD_W'($signed({1'b0, r_fac}));
            r_prod_z <= PROD_W'(r_shift_z) * PROD_W'($signed({1'b0, r_fac}));
        end
        // round, add and saturate
        if (w_en[11]) begin
            r_out_x <= move_axis(r_pt[PT_STAGES-1].x, r_prod_x);
            r_out_y <= move_axis(r_pt[PT_STAGES-1].y, r_prod_y);
            r_out_z <= move_axis(r_pt[PT_STAGES-1].z, r_prod_z);
        end
    end

endmodule

// ===== tb/sv/tb_gaussian_point_deform.sv =====
`timescale 1ns / 1ps

module tb_gaussian_point_deform;
    import gpd_pkg::*;

    localparam int EXP_DEPTH   = 256;
    localparam int STALL_PCT   = 28;
    localparam int HOLD_CYCLES = 80;
    localparam int PRINT_LIMIT = 100;

    localparam logic [CFG_IDX_W-1:0]      CFG_UNUSED = 3'd7;
    localparam logic signed [COORD_W-1:0] COORD_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN  = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] Q16_ONE    = 32'sh0001_0000;
    localparam logic [63:0]               ARG_LIMIT  = 64'd1 << U_FRAC_W;
    localparam longint                    SAT_HIGH   = 64'sd2147483647;
    localparam longint                    SAT_LOW    = -64'sd2147483648;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [COORD_W-1:0]        i_cfg_data  = '0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_stall;
    logic signed [COORD_W-1:0] i_point_x   = '0;
    logic signed [COORD_W-1:0] i_point_y   = '0;
    logic signed [COORD_W-1:0] i_point_z   = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b1;
    logic signed [COORD_W-1:0] o_moved_x;
    logic signed [COORD_W-1:0] o_moved_y;
    logic signed [COORD_W-1:0] o_moved_z;

    // Shadow copy of the configuration registers
    t_point             cfg_center;
    t_point             cfg_shift;
    logic [COORD_W-1:0] cfg_falloff;

    logic [TAB_W-1:0] exp_rom [EXP_DEPTH+1];
    t_point           moved_expect_q [$];
    t_point           moved_want;
    int               mismatch_count = 0;
    logic             calm     = 1'b0;
    logic             out_hold = 1'b0;

    gaussian_point_deform #(
        .EXP_TABLE_DEPTH (EXP_DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_point_z   (i_point_z),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_moved_x   (o_moved_x),
        .o_moved_y   (o_moved_y),
        .o_moved_z   (o_moved_z)
    );

    always #2 i_clk = ~i_clk;

    // Q.31 series for exp(-f), f up to 1.0
    function automatic logic [63:0] neg_exp_q31(input logic [63:0] f);
        logic [63:0] acc;
        logic [63:0] term;
        int          i;
        acc  = 64'd1 << 31;
        term = acc;
        for (i = 1; i <= 14; i++) begin
            term = ((term * f) >> 31) / 64'(i);
            if (i % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        return acc;
    endfunction

    // Fill the exp(-16k/depth) lookup, Q1.16
    initial begin : exp_rom_init
        logic [63:0] e_pow [17];
        logic [63:0] e_one;
        logic [63:0] x;
        logic [63:0] whole;
        logic [63:0] fract;
        logic [63:0] entry;
        int          n;
        int          k;
        e_one    = neg_exp_q31(64'd1 << 31);
        e_pow[0] = 64'd1 << 31;
        for (n = 1; n <= 16; n++) begin
            e_pow[n] = (e_pow[n-1] * e_one + (64'd1 << 30)) >> 31;
        end
        for (k = 0; k <= EXP_DEPTH; k++) begin
            x     = (64'(k) << 35) / 64'(EXP_DEPTH);
            whole = x >> 31;
            fract = x & ((64'd1 << 31) - 64'd1);
            if (whole > 64'd16) begin
                whole = 64'd16;
            end
            entry      = (neg_exp_q31(fract) * e_pow[int'(whole)] + (64'd1 << 45)) >> 46;
            exp_rom[k] = entry[TAB_W-1:0];
        end
    end

    // Add the rounded scaled shift to one coordinate and clamp
    function automatic logic signed [COORD_W-1:0] shifted_coord(
        input logic signed [COORD_W-1:0] coord,
        input logic signed [COORD_W-1:0] vec,
        input logic [63:0]               gain
    );
        longint scaled;
        longint total;
        scaled = longint'(vec) * longint'(gain);
        total  = longint'(coord) + ((scaled + 64'sd32768) >>> 16);
        if (total > SAT_HIGH) return COORD_MAX;
        if (total < SAT_LOW) return COORD_MIN;
        return total[COORD_W-1:0];
    endfunction

    // Displaced point under the current shadow configuration
    function automatic t_point predict_moved(input t_point p);
        logic signed [COORD_W-1:0] pc [3];
        logic signed [COORD_W-1:0] cc [3];
        logic [63:0]               dist2;
        logic [63:0]               arg;
        logic [63:0]               pos;
        logic [63:0]               frac;
        logic [63:0]               gain;
        logic [63:0]               mag;
        logic [64:0]               acc;
        longint                    diff;
        int                        ax;
        int                        k;
        t_point                    res;
        pc[0] = p.x;
        pc[1] = p.y;
        pc[2] = p.z;
        cc[0] = cfg_center.x;
        cc[1] = cfg_center.y;
        cc[2] = cfg_center.z;
        // Squared distance in Q32.32, saturating
        dist2 = '0;
        for (ax = 0; ax < 3; ax++) begin
            diff  = longint'(pc[ax]) - longint'(cc[ax]);
            mag   = (diff < 0) ? 64'(-diff) : 64'(diff);
            acc   = {1'b0, dist2} + {1'b0, mag * mag};
            dist2 = acc[64] ? '1 : acc[63:0];
        end
        arg = (dist2 >> 32) * 64'(cfg_falloff)
            + (((dist2 & 64'hFFFF_FFFF) * 64'(cfg_falloff)) >> 32);
        // Interpolate the lookup; far points get no shift
        gain = '0;
        if (arg < ARG_LIMIT) begin
            pos  = arg * 64'(EXP_DEPTH);
            k    = int'(pos >> U_FRAC_W);
            frac = pos & (ARG_LIMIT - 64'd1);
            gain = (64'(exp_rom[k]) * (ARG_LIMIT - frac) + 64'(exp_rom[k+1]) * frac
                 + (ARG_LIMIT >> 1)) >> U_FRAC_W;
        end
        res.x = shifted_coord(p.x, cfg_shift.x, gain);
        res.y = shifted_coord(p.y, cfg_shift.y, gain);
        res.z = shifted_coord(p.z, cfg_shift.z, gain);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) $display("%0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Log-spread magnitude with random sign
    function automatic logic [COORD_W-1:0] spread_offset();
        logic [COORD_W-1:0] v;
        v = $urandom >> $urandom_range(0, 31);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // Mostly points around the centre, some anywhere
    function automatic t_point pick_point(input t_point ctr);
        t_point p;
        if ($urandom_range(0, 99) < 15) begin
            p.x = $urandom;
            p.y = $urandom;
            p.z = $urandom;
        end else begin
            p.x = ctr.x + spread_offset();
            p.y = ctr.y + spread_offset();
            p.z = ctr.z + spread_offset();
        end
        return p;
    endfunction

    // Offer one point, hold it until taken, then queue its expected result
    task automatic send_point(input t_point p);
        while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_point_x  <= p.x;
        i_point_y  <= p.y;
        i_point_z  <= p.z;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        moved_expect_q.push_back(predict_moved(p));
    endtask

    // Stop offering and wait until every expected transaction is back
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (moved_expect_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_CENTER_X: cfg_center.x = data;
            CFG_CENTER_Y: cfg_center.y = data;
            CFG_CENTER_Z: cfg_center.z = data;
            CFG_SHIFT_X:  cfg_shift.x  = data;
            CFG_SHIFT_Y:  cfg_shift.y  = data;
            CFG_SHIFT_Z:  cfg_shift.z  = data;
            CFG_FALLOFF:  cfg_falloff  = data;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input t_point ctr, input t_point shf,
                                  input logic [COORD_W-1:0] rate);
        wait_results_done();
        cfg_write(CFG_CENTER_X, ctr.x);
        cfg_write(CFG_CENTER_Y, ctr.y);
        cfg_write(CFG_CENTER_Z, ctr.z);
        cfg_write(CFG_SHIFT_X, shf.x);
        cfg_write(CFG_SHIFT_Y, shf.y);
        cfg_write(CFG_SHIFT_Z, shf.z);
        cfg_write(CFG_FALLOFF, rate);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Registers untouched since reset: zero shift leaves points in place
    task automatic test_reset_values();
        send_point({32'sd0, 32'sd0, 32'sd0});
        send_point({COORD_MAX, COORD_MIN, Q16_ONE});
        send_point({COORD_MIN, COORD_MAX, -Q16_ONE});
    endtask

    // Zero falloff gives the full shift; drive both ends into saturation
    task automatic test_zero_falloff();
        apply_settings({32'sh1234_5678, -32'sh0765_4321, 32'sd0},
                       {COORD_MAX, COORD_MIN, 32'sh0001_2345}, '0);
        send_point({COORD_MAX, COORD_MIN, COORD_MAX});
        send_point({COORD_MIN, COORD_MAX, COORD_MIN});
        send_point({32'sd0, 32'sd0, 32'sd0});
        send_point({32'sh4000_0000, 32'sh4000_0000, 32'sh7FFE_DCBA});
    endtask

    // Unit falloff: distance 4.0 is the edge of the lookup
    task automatic test_falloff_boundary();
        apply_settings({32'sd0, 32'sd0, 32'sd0},
                       {Q16_ONE, -32'sh0003_0000, COORD_MAX}, FALLOFF_RESET);
        send_point({32'sd0, 32'sd0, 32'sd0});
        send_point({32'sh0004_0000, 32'sd0, 32'sd0});
        send_point({32'sh0003_FFFF, 32'sd0, 32'sd0});
        send_point({32'sd0, 32'sd0, -32'sh0004_0000});
        send_point({32'sh0002_0000, 32'sh0000_8000, -32'sh0000_4000});
        send_point({COORD_MIN, COORD_MIN, COORD_MIN});
        // Largest falloff, points barely off the centre
        apply_settings({32'sd0, 32'sd0, 32'sd0},
                       {Q16_ONE, -32'sh0003_0000, COORD_MAX}, '1);
        send_point({32'sd1, 32'sd0, 32'sd0});
        send_point({32'sh0000_0100, 32'sh0000_0100, 32'sd0});
    endtask

    // Opposite corners overflow the squared distance sum
    task automatic test_distance_saturation();
        apply_settings({COORD_MIN, COORD_MIN, COORD_MIN},
                       {32'sd1, -32'sd1, COORD_MAX}, '0);
        send_point({COORD_MAX, COORD_MAX, COORD_MAX});
        send_point({COORD_MAX, COORD_MIN, COORD_MAX});
        apply_settings({COORD_MIN, COORD_MIN, COORD_MIN},
                       {32'sd1, -32'sd1, COORD_MAX}, 32'd1);
        send_point({COORD_MAX, COORD_MAX, COORD_MAX});
    endtask

    // A write to an index past the register list must change nothing
    task automatic test_ignored_index();
        wait_results_done();
        cfg_write(CFG_UNUSED, '1);
        i_cfg_wr_en <= 1'b0;
        send_point({COORD_MIN, COORD_MIN, COORD_MIN});
        send_point({COORD_MIN + 32'sh10, COORD_MIN, COORD_MIN + 32'sh7});
    endtask

    task automatic test_random_settings();
        t_point             ctr;
        t_point             shf;
        logic [COORD_W-1:0] rate;
        int                 ph;
        for (ph = 0; ph < 6; ph++) begin
            ctr  = {$urandom, $urandom, $urandom};
            shf  = {$urandom, $urandom, $urandom};
            rate = $urandom >> $urandom_range(0, 31);
            case (ph)
                1: begin
                    shf = {spread_offset(), spread_offset(), spread_offset()};
                end
                2: begin
                    ctr  = {COORD_MAX, COORD_MIN, COORD_MAX};
                    shf  = {COORD_MAX, COORD_MIN, Q16_ONE};
                    rate = '0;
                end
                3: begin
                    ctr  = {COORD_MIN, COORD_MAX, 32'sd0};
                    shf  = {COORD_MIN, COORD_MAX, shf.z};
                    rate = '1;
                end
                4: begin
                    ctr  = {spread_offset(), spread_offset(), spread_offset()};
                    rate = FALLOFF_RESET;
                end
                default: ;
            endcase
            apply_settings(ctr, shf, rate);
            repeat (190) send_point(pick_point(ctr));
        end
    endtask

    // Hold the output long enough to pack the pipeline, then let it drain
    task automatic test_output_hold();
        t_point ctr;
        t_point shf;
        ctr = {$urandom, $urandom, $urandom};
        shf = {$urandom, $urandom, $urandom};
        apply_settings(ctr, shf, $urandom >> $urandom_range(0, 16));
        fork
            begin
                out_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                out_hold <= 1'b0;
            end
            repeat (60) send_point(pick_point(ctr));
        join
        wait_results_done();
        repeat (40) send_point(pick_point(ctr));
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_steady_stream();
        t_point ctr;
        t_point shf;
        ctr = {spread_offset(), spread_offset(), spread_offset()};
        shf = {$urandom, $urandom, $urandom};
        apply_settings(ctr, shf, $urandom >> $urandom_range(4, 24));
        calm <= 1'b1;
        repeat (150) send_point(pick_point(ctr));
        calm <= 1'b0;
    endtask

    // Output stall: long hold, steady stretch, otherwise random
    always @(posedge i_clk) begin
        if (out_hold) begin
            i_out_stall <= 1'b1;
        end else if (calm) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < STALL_PCT);
        end
    end

    // Compare each moved point with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (moved_expect_q.size() == 0) begin
                report_mismatch($sformatf("moved point with none pending: %h %h %h",
                                          o_moved_x, o_moved_y, o_moved_z));
            end else begin
                moved_want = moved_expect_q.pop_front();
                if (o_moved_x !== moved_want.x)
                    report_mismatch($sformatf("moved_x got %h expected %h",
                                              o_moved_x, moved_want.x));
                if (o_moved_y !== moved_want.y)
                    report_mismatch($sformatf("moved_y got %h expected %h",
                                              o_moved_y, moved_want.y));
                if (o_moved_z !== moved_want.z)
                    report_mismatch($sformatf("moved_z got %h expected %h",
                                              o_moved_z, moved_want.z));
            end
        end
    end

    initial begin
        cfg_center  = '0;
        cfg_shift   = '0;
        cfg_falloff = FALLOFF_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_zero_falloff();
        test_falloff_boundary();
        test_distance_saturation();
        test_ignored_index();
        test_random_settings();
        test_output_hold();
        test_steady_stream();
        wait_results_done();
        repeat (NUM_STAGES + 4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[gaussian_point_deform] OK");
        end else begin
            $display("[gaussian_point_deform] ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("[gaussian_point_deform] ERROR");
        $finish;
    end

endmodule
